/* design/polyline_metrics_accumulator_assert.svh */
// ----------------------------------------------------------------------------
// Polyline metrics accumulator assertion macros
// Clocked property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_METRICS_ACCUMULATOR_ASSERT_SVH
`define POLYLINE_METRICS_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTHESIS
// check on every edge outside reset
`define PMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every edge, reset included
`define PMA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMA_ASSERT(label, prop, msg)
`define PMA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* design/pma_pkg.sv */
// ----------------------------------------------------------------------------
// Polyline metrics package
// Shared constants, multiplier operation codes and square root status type.
// ----------------------------------------------------------------------------
package pma_pkg;

  // default widths
  localparam int COORD_BITS_DEF  = 31;
  localparam int LENGTH_BITS_DEF = 48;

  // fixed widths of the shoelace sum and the area result
  localparam int CROSS_BITS = 64;
  localparam int AREA_BITS  = 63;

  // vertex count codes (count saturates at three)
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_MAX  = 2'd3;

  // products formed by the shared multiplier
  typedef enum logic [1:0] {
    MUL_DX_SQ,
    MUL_DY_SQ,
    MUL_PX_Y,
    MUL_X_PY
  } mul_op_t;

  // square root unit status
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

/* design/pma_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Selects one of four coordinate products and registers the result.
// ----------------------------------------------------------------------------
module pma_mul #(
  parameter int CW = pma_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  pma_pkg::mul_op_t        op,
  input  logic [CW-1:0]           dx,
  input  logic [CW-1:0]           dy,
  input  logic signed [CW-1:0]    prev_x,
  input  logic signed [CW-1:0]    prev_y,
  input  logic signed [CW-1:0]    x,
  input  logic signed [CW-1:0]    y,
  output logic signed [2*CW+1:0]  prod
);

  logic signed [CW:0] opa;
  logic signed [CW:0] opb;

  // operand select; magnitudes are zero extended
  always_comb begin
    unique case (op)
      pma_pkg::MUL_DX_SQ: begin
        opa = $signed({1'b0, dx});
        opb = $signed({1'b0, dx});
      end
      pma_pkg::MUL_DY_SQ: begin
        opa = $signed({1'b0, dy});
        opb = $signed({1'b0, dy});
      end
      pma_pkg::MUL_PX_Y: begin
        opa = {prev_x[CW-1], prev_x};
        opb = {y[CW-1], y};
      end
      pma_pkg::MUL_X_PY: begin
        opa = {x[CW-1], x};
        opb = {prev_y[CW-1], prev_y};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

endmodule

/* design/pma_isqrt.sv */
// ----------------------------------------------------------------------------
// Iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pma_isqrt #(
  parameter int ROOT_W = pma_pkg::COORD_BITS_DEF + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [2*ROOT_W-1:0]     radicand,
  output logic [ROOT_W-1:0]       root,
  output pma_pkg::sqrt_stat_t     stat
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W+1:0]   rem;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [ROOT_W+1:0]   rem_shift;
  logic [ROOT_W+1:0]   trial;
  logic                fits;

  // bring down two radicand bits and try the next root bit
  assign rem_shift = {rem[ROOT_W-1:0], rad[2*ROOT_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign fits      = rem_shift >= trial;

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*ROOT_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_shift - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* design/polyline_metrics_accumulator.sv */
// ----------------------------------------------------------------------------
// Polyline metrics accumulator
// Bounding box, summed segment length and shoelace area of one polyline.
// ----------------------------------------------------------------------------
// First vertex of a polyline: captured in the first state, then ready again.
// Other vertices pass through the difference, multiplier, square root and update
// states: four shared-multiplier passes, bit-serial root of COORD_BITS + 1 steps.
// Final vertex: emit state; its result sits in an output register until taken.
// Synchronous active-high reset clears all accumulated state and the output valid.
module polyline_metrics_accumulator #(
  parameter int COORD_BITS  = pma_pkg::COORD_BITS_DEF,
  parameter int LENGTH_BITS = pma_pkg::LENGTH_BITS_DEF,
  localparam int IN_W  = ((2*COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4*COORD_BITS + LENGTH_BITS + pma_pkg::AREA_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // x_coord, y_coord
  input  logic              s_tlast,   // last_point
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // min_x, max_x, min_y, max_y, total_length, area_twice
  output logic [1:0]        m_tuser    // is_closed, is_clockwise
);

`include "polyline_metrics_accumulator_assert.svh"

  localparam int CW      = COORD_BITS;
  localparam int LW      = LENGTH_BITS;
  localparam int ROOT_W  = CW + 1;
  localparam int SQ_W    = 2*CW + 1;
  localparam int PROD_W  = 2*CW + 2;
  localparam int XW      = pma_pkg::CROSS_BITS;
  localparam int AW      = pma_pkg::AREA_BITS;
  localparam int SUM_W   = ((LW > ROOT_W) ? LW : ROOT_W) + 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIRST  = 3'd1;
  localparam logic [2:0] ST_DIFF   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SQRT   = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  localparam logic [2:0] MUL_LAST = 3'd4;

  logic [2:0] state;
  logic [2:0] mcnt;

  // latched request
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;
  logic                 in_last;

  // polyline state
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] prev_x;
  logic signed [CW-1:0] prev_y;
  logic signed [CW-1:0] box_min_x;
  logic signed [CW-1:0] box_max_x;
  logic signed [CW-1:0] box_min_y;
  logic signed [CW-1:0] box_max_y;
  logic [LW-1:0]        length_sum;
  logic signed [XW-1:0] cross_sum;
  logic [1:0]           seen_count;

  // per-segment working values
  logic [CW-1:0]            dx;
  logic [CW-1:0]            dy;
  logic [SQ_W-1:0]          sq;
  logic signed [PROD_W-1:0] cr;

  // output register
  logic signed [CW-1:0] o_min_x;
  logic signed [CW-1:0] o_max_x;
  logic signed [CW-1:0] o_min_y;
  logic signed [CW-1:0] o_max_y;
  logic [LW-1:0]        o_length;
  logic [AW-1:0]        o_area;
  logic                 o_closed;
  logic                 o_cw;

  // shared units
  logic signed [PROD_W-1:0] prod;
  pma_pkg::mul_op_t         mul_op;
  logic                     sq_start;
  logic [ROOT_W-1:0]        seg;
  pma_pkg::sqrt_stat_t      sq_stat;

  logic s_acc;
  logic out_free;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign mul_op   = pma_pkg::mul_op_t'(mcnt[1:0]);
  assign sq_start = (state == ST_MUL) && (mcnt == MUL_LAST);

  pma_mul #(
    .CW(CW)
  ) u_mul (
    .clk    (clk),
    .op     (mul_op),
    .dx     (dx),
    .dy     (dy),
    .prev_x (prev_x),
    .prev_y (prev_y),
    .x      (in_x),
    .y      (in_y),
    .prod   (prod)
  );

  pma_isqrt #(
    .ROOT_W(ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ((2*ROOT_W)'(sq)),
    .root     (seg),
    .stat     (sq_stat)
  );

  // coordinate differences, magnitudes
  logic signed [CW:0] dxs;
  logic signed [CW:0] dys;
  logic [CW:0]        dxn;
  logic [CW:0]        dyn;
  assign dxs = {in_x[CW-1], in_x} - {prev_x[CW-1], prev_x};
  assign dys = {in_y[CW-1], in_y} - {prev_y[CW-1], prev_y};
  assign dxn = -dxs;
  assign dyn = -dys;

  // saturating length sum
  logic [SUM_W-1:0] len_add;
  logic [LW-1:0]    len_next;
  assign len_add  = SUM_W'(length_sum) + SUM_W'(seg);
  assign len_next = (len_add[SUM_W-1:LW] != '0) ? {LW{1'b1}} : len_add[LW-1:0];

  // saturating shoelace sum
  logic signed [XW:0]   cross_add;
  logic signed [XW-1:0] cross_next;
  assign cross_add = {cross_sum[XW-1], cross_sum}
                   + {{(XW+1-PROD_W){cr[PROD_W-1]}}, cr};
  always_comb begin
    if (cross_add[XW] != cross_add[XW-1]) begin
      cross_next = cross_add[XW] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
    end else begin
      cross_next = cross_add[XW-1:0];
    end
  end

  // result of the final vertex (closing term is zero when closed)
  logic          closed;
  logic          cw_flag;
  logic [XW-1:0] cross_neg;
  logic [AW-1:0] area;
  assign closed    = (seen_count == pma_pkg::SEEN_MAX) && (in_x == first_x)
                     && (in_y == first_y);
  assign cross_neg = -cross_sum;
  always_comb begin
    cw_flag = 1'b0;
    area    = '0;
    if (closed) begin
      if (cross_sum[XW-1]) begin
        cw_flag = 1'b1;
        area    = cross_neg[XW-1] ? {AW{1'b1}} : cross_neg[AW-1:0];
      end else begin
        area = cross_sum[AW-1:0];
      end
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mcnt       <= '0;
      seen_count <= pma_pkg::SEEN_NONE;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      box_min_x  <= '0;
      box_max_x  <= '0;
      box_min_y  <= '0;
      box_max_y  <= '0;
      length_sum <= '0;
      cross_sum  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // output valid: set when a result is loaded, cleared when taken
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            state <= (seen_count == pma_pkg::SEEN_NONE) ? ST_FIRST : ST_DIFF;
          end
        end
        ST_FIRST: begin
          first_x    <= in_x;
          first_y    <= in_y;
          prev_x     <= in_x;
          prev_y     <= in_y;
          box_min_x  <= in_x;
          box_max_x  <= in_x;
          box_min_y  <= in_y;
          box_max_y  <= in_y;
          length_sum <= '0;
          cross_sum  <= '0;
          seen_count <= pma_pkg::SEEN_ONE;
          state      <= in_last ? ST_EMIT : ST_IDLE;
        end
        ST_DIFF: begin
          mcnt  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          mcnt <= mcnt + 1'b1;
          if (mcnt == MUL_LAST) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_stat.done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          length_sum <= len_next;
          cross_sum  <= cross_next;
          if (in_x < box_min_x) box_min_x <= in_x;
          if (in_x > box_max_x) box_max_x <= in_x;
          if (in_y < box_min_y) box_min_y <= in_y;
          if (in_y > box_max_y) box_max_y <= in_y;
          if (seen_count != pma_pkg::SEEN_MAX) begin
            seen_count <= seen_count + 1'b1;
          end
          prev_x <= in_x;
          prev_y <= in_y;
          state  <= in_last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            seen_count <= pma_pkg::SEEN_NONE;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request capture and segment datapath
  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_x    <= s_tdata[CW-1:0];
      in_y    <= s_tdata[2*CW-1:CW];
      in_last <= s_tlast;
    end
    if (state == ST_DIFF) begin
      dx <= dxs[CW] ? dxn[CW-1:0] : dxs[CW-1:0];
      dy <= dys[CW] ? dyn[CW-1:0] : dys[CW-1:0];
    end
    // product of step k is registered and used at step k + 1
    if (state == ST_MUL) begin
      case (mcnt)
        3'd1: sq <= prod[SQ_W-1:0];
        3'd2: sq <= sq + prod[SQ_W-1:0];
        3'd3: cr <= prod;
        3'd4: cr <= cr - prod;
        default: ;
      endcase
    end
  end

  // output register load
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      o_min_x  <= box_min_x;
      o_max_x  <= box_max_x;
      o_min_y  <= box_min_y;
      o_max_y  <= box_max_y;
      o_length <= length_sum;
      o_area   <= area;
      o_closed <= closed;
      o_cw     <= cw_flag;
    end
  end

  assign m_tdata = OUT_W'({o_area, o_length, o_max_y, o_min_y, o_max_x, o_min_x});
  assign m_tuser = {o_cw, o_closed};

  // checks
  `PMA_ASSERT(a_sqrt_idle, (state == ST_IDLE) |-> !sq_stat.busy, "square root busy while idle")
  `PMA_ASSERT(a_cw_closed, m_tvalid |-> (!o_cw || o_closed), "clockwise set on open polyline")
  `PMA_ASSERT(a_open_area, (m_tvalid && !o_closed) |-> (o_area == '0), "open polyline with area")
  `PMA_ASSERT(a_box_order, ((state == ST_IDLE) && (seen_count != pma_pkg::SEEN_NONE)) |-> ((box_min_x <= box_max_x) && (box_min_y <= box_max_y)), "bounding box inverted")
  `PMA_ASSERT_ALWAYS(a_rst_out, rst |=> !m_tvalid, "output valid after reset")

endmodule

/* verif/tb_polyline_metrics_accumulator.sv */
// ----------------------------------------------------------------------------
// Polyline metrics accumulator testbench
// Streams polylines into the block and checks every report against a
// behavioral predictor of box, floored segment length, shoelace area and the
// closed/clockwise flags. Directed shapes and saturation cases come first,
// then random polylines, with random gaps on the vertex side and random
// backpressure on the report side.
// ----------------------------------------------------------------------------
module tb_polyline_metrics_accumulator;

  localparam int COORD_W = pma_pkg::COORD_BITS_DEF;
  localparam int LEN_W   = pma_pkg::LENGTH_BITS_DEF;
  localparam int AREA_W  = pma_pkg::AREA_BITS;
  localparam int IN_W    = ((2*COORD_W + 7) / 8) * 8;
  localparam int OUT_W   = ((4*COORD_W + LEN_W + AREA_W + 7) / 8) * 8;
  localparam int OFF_LEN  = 4*COORD_W;
  localparam int OFF_AREA = 4*COORD_W + LEN_W;

  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [63:0] LEN_MAX = (64'd1 << LEN_W) - 64'd1;
  localparam logic signed [pma_pkg::CROSS_BITS-1:0] CROSS_MIN =
    {1'b1, {(pma_pkg::CROSS_BITS-1){1'b0}}};
  localparam logic signed [pma_pkg::CROSS_BITS-1:0] CROSS_MAX =
    {1'b0, {(pma_pkg::CROSS_BITS-1){1'b1}}};
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
  localparam int TAIL_CYCLES = 3*COORD_W;
  localparam int RUN_LIMIT   = 2_000_000;

  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
    logic [LEN_W-1:0]   total_length;
    logic [AREA_W-1:0]  area_twice;
    logic               is_closed;
    logic               is_clockwise;
  } poly_report_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // x_coord, y_coord
  logic             s_tlast = 1'b0; // last_point
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // min_x, max_x, min_y, max_y, total_length, area_twice
  logic [1:0]       m_tuser;        // is_closed, is_clockwise

  polyline_metrics_accumulator #(
    .COORD_BITS  (COORD_W),
    .LENGTH_BITS (LEN_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state for the polyline in flight
  logic signed [63:0] pl_first_x, pl_first_y, pl_prev_x, pl_prev_y;
  logic signed [63:0] pl_min_x, pl_max_x, pl_min_y, pl_max_y;
  logic signed [63:0] pl_cross;
  logic [63:0]        pl_length;
  logic [1:0]         pl_seen;

  poly_report_t metrics_expect_q[$];
  logic signed [COORD_W-1:0] path_x[$];
  logic signed [COORD_W-1:0] path_y[$];

  int errors = 0;
  int vertices_sent = 0;
  int polylines_sent = 0;
  int reports_checked = 0;
  int closed_seen = 0;
  int cw_seen = 0;
  int len_sat_seen = 0;
  int area_sat_seen = 0;
  bit tx_idle_on = 1'b1;
  bit rx_stall_on = 1'b1;
  int rx_hold = 0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // floor(sqrt(n)), bit by bit
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] v, r, b;
    v = n;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // signed 64-bit add that clamps at both limits
  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] t);
    logic signed [64:0] w;
    w = a + t;
    if (w[64] != w[63]) return w[64] ? CROSS_MIN : CROSS_MAX;
    return w[63:0];
  endfunction

  // advance the predictor by one accepted vertex; queue a report on the last
  task automatic track_vertex(input logic signed [COORD_W-1:0] x_in,
                              input logic signed [COORD_W-1:0] y_in,
                              input logic last);
    logic signed [63:0] x, y, s;
    logic [63:0] dx, dy, seg;
    poly_report_t rep;
    x = 64'(x_in);
    y = 64'(y_in);
    if (pl_seen == pma_pkg::SEEN_NONE) begin
      pl_first_x = x;
      pl_first_y = y;
      pl_min_x = x;
      pl_max_x = x;
      pl_min_y = y;
      pl_max_y = y;
      pl_length = '0;
      pl_cross = '0;
      pl_seen = pma_pkg::SEEN_ONE;
    end else begin
      dx = (x >= pl_prev_x) ? x - pl_prev_x : pl_prev_x - x;
      dy = (y >= pl_prev_y) ? y - pl_prev_y : pl_prev_y - y;
      seg = root_floor(dx*dx + dy*dy);
      if (seg > LEN_MAX - pl_length) pl_length = LEN_MAX;
      else pl_length = pl_length + seg;
      pl_cross = clamp_add(pl_cross, pl_prev_x*y - x*pl_prev_y);
      if (x < pl_min_x) pl_min_x = x;
      if (x > pl_max_x) pl_max_x = x;
      if (y < pl_min_y) pl_min_y = y;
      if (y > pl_max_y) pl_max_y = y;
      if (pl_seen != pma_pkg::SEEN_MAX) pl_seen = pl_seen + 2'd1;
    end
    pl_prev_x = x;
    pl_prev_y = y;
    if (last) begin
      rep = '0;
      rep.min_x = pl_min_x[COORD_W-1:0];
      rep.max_x = pl_max_x[COORD_W-1:0];
      rep.min_y = pl_min_y[COORD_W-1:0];
      rep.max_y = pl_max_y[COORD_W-1:0];
      rep.total_length = pl_length[LEN_W-1:0];
      rep.is_closed = (pl_seen == pma_pkg::SEEN_MAX) && (x == pl_first_x)
                      && (y == pl_first_y);
      if (rep.is_closed) begin
        s = clamp_add(pl_cross, x*pl_first_y - pl_first_x*y);
        if (s < 0) begin
          rep.is_clockwise = 1'b1;
          rep.area_twice = (s == CROSS_MIN) ? AREA_MAX : AREA_W'(-s);
        end else begin
          rep.area_twice = AREA_W'(s);
        end
      end
      metrics_expect_q.push_back(rep);
      pl_seen = pma_pkg::SEEN_NONE;
    end
  endtask

  // one vertex request, predicted at the edge where it is taken
  task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic last);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-2*COORD_W){1'b0}}, y, x};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_vertex(x, y, last);
    vertices_sent++;
  endtask

  task automatic add_point(input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    path_x.push_back(x);
    path_y.push_back(y);
  endtask

  // send the collected path, last flag on its final vertex
  task automatic send_path();
    int i;
    for (i = 0; i < path_x.size(); i++)
      send_vertex(path_x[i], path_y[i], i == path_x.size() - 1);
    path_x.delete();
    path_y.delete();
    polylines_sent++;
  endtask

  task automatic wait_reports_drained();
    s_tvalid <= 1'b0;
    while (metrics_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input int style, input int base);
    case (style)
      0: return COORD_W'($urandom());
      1: return COORD_W'(base + $urandom_range(0, 64) - 32);
      default: begin
        case ($urandom_range(0, 5))
          0: return CMIN;
          1: return CMAX;
          2: return '0;
          3: return '1;
          4: return COORD_W'(1);
          default: return COORD_W'($urandom());
        endcase
      end
    endcase
  endfunction

  // report side backpressure
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= 1'b1;
      if (rx_stall_on && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
    end
  end

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  // report checker
  always @(posedge clk) begin : report_check
    poly_report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.min_x = m_tdata[0*COORD_W +: COORD_W];
      got.max_x = m_tdata[1*COORD_W +: COORD_W];
      got.min_y = m_tdata[2*COORD_W +: COORD_W];
      got.max_y = m_tdata[3*COORD_W +: COORD_W];
      got.total_length = m_tdata[OFF_LEN +: LEN_W];
      got.area_twice = m_tdata[OFF_AREA +: AREA_W];
      got.is_closed = m_tuser[0];
      got.is_clockwise = m_tuser[1];
      if (metrics_expect_q.size() == 0) begin
        $display("%0t: report with none expected, actual %0h", $time, got);
        errors++;
      end else begin
        want = metrics_expect_q.pop_front();
        compare_field("min_x", 64'(want.min_x), 64'(got.min_x));
        compare_field("max_x", 64'(want.max_x), 64'(got.max_x));
        compare_field("min_y", 64'(want.min_y), 64'(got.min_y));
        compare_field("max_y", 64'(want.max_y), 64'(got.max_y));
        compare_field("total_length", 64'(want.total_length), 64'(got.total_length));
        compare_field("area_twice", 64'(want.area_twice), 64'(got.area_twice));
        compare_field("is_closed", 64'(want.is_closed), 64'(got.is_closed));
        compare_field("is_clockwise", 64'(want.is_clockwise), 64'(got.is_clockwise));
        reports_checked++;
        if (want.is_closed) closed_seen++;
        if (want.is_clockwise) cw_seen++;
        if (want.total_length == LEN_MAX[LEN_W-1:0]) len_sat_seen++;
        if (want.area_twice == AREA_MAX) area_sat_seen++;
      end
    end
  end

  // small shapes covering each flag combination
  task automatic test_directed_shapes();
    int i;
    // lone vertex at the coordinate extremes
    add_point(CMIN, CMAX);
    send_path();
    // two points, open, 3-4-5 segment
    add_point(0, 0);
    add_point(3, 4);
    send_path();
    // counterclockwise triangle, closed
    add_point(0, 0);
    add_point(10, 0);
    add_point(0, 10);
    add_point(0, 0);
    send_path();
    // clockwise triangle, closed
    add_point(0, 0);
    add_point(0, 10);
    add_point(10, 0);
    add_point(0, 0);
    send_path();
    // out and back: closed with zero area
    add_point(-7, 5);
    add_point(9, -3);
    add_point(-7, 5);
    send_path();
    // three points that do not return to the start
    add_point(1, 1);
    add_point(5, 1);
    add_point(5, 5);
    send_path();
    // full-range square walked clockwise twice: negative area sum clamps
    for (i = 0; i < 2; i++) begin
      add_point(CMIN, CMIN);
      add_point(CMIN, CMAX);
      add_point(CMAX, CMAX);
      add_point(CMAX, CMIN);
    end
    add_point(CMIN, CMIN);
    send_path();
  endtask

  // positive area clamp and longest segments
  task automatic test_saturation();
    int i;
    for (i = 0; i < 2; i++) begin
      add_point(CMIN, CMIN);
      add_point(CMAX, CMIN);
      add_point(CMAX, CMAX);
      add_point(CMIN, CMAX);
    end
    add_point(CMIN, CMIN);
    send_path();
    // diagonal zigzag of longest segments, largest root inputs
    for (i = 0; i < 27; i++) begin
      if (i % 2 == 0) add_point(CMIN, CMIN);
      else add_point(CMAX, CMAX);
    end
    send_path();
  endtask

  task automatic test_random_polylines(input int target);
    int start, n, style, base_x, base_y, i, r;
    bit closed, drained_once;
    start = vertices_sent;
    drained_once = 1'b0;
    while (vertices_sent - start < target) begin
      tx_idle_on  = ($urandom_range(0, 4) != 0);
      rx_stall_on = ($urandom_range(0, 4) != 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      style = (r < 4) ? 0 : (r < 8) ? 1 : 2;
      base_x = $urandom_range(0, 1 << 30) - (1 << 29);
      base_y = $urandom_range(0, 1 << 30) - (1 << 29);
      closed = (n >= 3) && ($urandom_range(0, 9) < 6);
      for (i = 0; i < n; i++)
        add_point(pick_coord(style, base_x), pick_coord(style, base_y));
      if (closed) add_point(path_x[0], path_y[0]);
      send_path();
      // hold off the sender until every report is back
      if ((!drained_once && vertices_sent - start > target / 2) ||
          $urandom_range(0, 49) == 0) begin
        wait_reports_drained();
        drained_once = 1'b1;
      end
    end
  endtask

  initial begin
    pl_first_x = '0;
    pl_first_y = '0;
    pl_prev_x = '0;
    pl_prev_y = '0;
    pl_min_x = '0;
    pl_max_x = '0;
    pl_min_y = '0;
    pl_max_y = '0;
    pl_cross = '0;
    pl_length = '0;
    pl_seen = pma_pkg::SEEN_NONE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_shapes();
    test_saturation();
    test_random_polylines(650);

    wait_reports_drained();
    $display("Run covered %0d vertices in %0d polylines, %0d reports checked",
             vertices_sent, polylines_sent, reports_checked);
    $display("  %0d closed, %0d clockwise, length clamped %0d, area clamped %0d",
             closed_seen, cw_seen, len_sat_seen, area_sat_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
